// ----- rtl/core/pgmc_pkg.sv -----
package pgmc_pkg;

    typedef enum logic [3:0] {
        PH_P, PH_FIVE, PH_SEP, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_AFTER_CR, PH_RASTER,
        PH_SINK
    } t_phase;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_LENGTH   = 3'd3;
    localparam logic [2:0] ST_ABOVE    = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // one classified beat: a raster byte and/or end of file, or a header result
    typedef struct packed {
        logic        raster;     // byte belongs to raster
        logic [7:0]  data;
        logic        eof;
        logic        hdr_ok;     // header finished cleanly (raster phase reached)
        logic [2:0]  err;        // header error, 0 if none
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] maxval;
        logic        setup;      // maxval separator: back loads expected size first
    } t_beat;

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D ||
               b == 8'h0B || b == 8'h0C;
    endfunction

endpackage

// ----- rtl/core/pgmc_front.sv -----
module pgmc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_file,
    input  logic              i_take,
    output pgmc_pkg::t_beat   o_beat
);
    import pgmc_pkg::*;

    t_phase      r_ph, n_ph;
    logic        r_cmt, n_cmt;
    logic [31:0] r_acc, n_acc;
    logic        r_dig, n_dig;
    logic [31:0] r_w, n_w, r_h, n_h;
    logic [15:0] r_mx, n_mx;
    logic [2:0]  r_err, n_err;
    logic        n_setup;
    logic [35:0] mul10;
    logic        digit;
    logic [7:0]  b;

    assign b     = i_data_byte;
    assign digit = b >= 8'h30 && b <= 8'h39;
    assign mul10 = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0} + {32'b0, b[3:0]};

    always_comb begin
        n_ph = r_ph; n_cmt = r_cmt; n_acc = r_acc; n_dig = r_dig;
        n_w = r_w; n_h = r_h; n_mx = r_mx; n_err = r_err; n_setup = 1'b0;
        o_beat = '0;
        unique case (r_ph)
            PH_P:    if (b == 8'h50) n_ph = PH_FIVE; else begin n_err = ST_HEADER; n_ph = PH_SINK; end
            PH_FIVE: if (b == 8'h35) n_ph = PH_SEP; else begin n_err = ST_HEADER; n_ph = PH_SINK; end
            PH_SEP:  if (is_space(b)) n_ph = PH_WIDTH; else begin n_err = ST_HEADER; n_ph = PH_SINK; end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                priority if (r_cmt) begin
                    if (b == 8'h0D || b == 8'h0A) n_cmt = 1'b0;
                end else if (!r_dig) begin
                    if (is_space(b)) begin
                    end else if (b == 8'h23) n_cmt = 1'b1;
                    else if (!digit) begin n_err = ST_HEADER; n_ph = PH_SINK; end
                    else begin n_acc = {28'b0, b[3:0]}; n_dig = 1'b1; end
                end else if (digit) begin
                    if (mul10[35:32] != 4'b0) begin n_err = ST_HEADER; n_ph = PH_SINK; end
                    else n_acc = mul10[31:0];
                end else if ((!is_space(b) && b != 8'h23) || r_acc == 32'b0) begin
                    n_err = ST_HEADER; n_ph = PH_SINK;
                end else if (r_ph == PH_MAXVAL) begin
                    if (!is_space(b) || r_acc[31:16] != 16'b0) begin
                        n_err = ST_HEADER; n_ph = PH_SINK;
                    end else begin
                        n_mx = r_acc[15:0]; n_dig = 1'b0; n_acc = '0; n_setup = 1'b1;
                        n_ph = (b == 8'h0D) ? PH_AFTER_CR : PH_RASTER;
                    end
                end else begin
                    if (r_ph == PH_WIDTH) n_w = r_acc; else n_h = r_acc;
                    n_acc = '0; n_dig = 1'b0; n_cmt = (b == 8'h23);
                    n_ph = (r_ph == PH_WIDTH) ? PH_HEIGHT : PH_MAXVAL;
                end
            end
            PH_AFTER_CR: begin
                n_ph = PH_RASTER;
                o_beat.raster = (b != 8'h0A);
            end
            PH_RASTER: o_beat.raster = 1'b1;
            default:   n_ph = PH_SINK;
        endcase
        o_beat.data   = b;
        o_beat.eof    = i_end_of_file;
        o_beat.setup  = n_setup;
        o_beat.width  = r_w;
        o_beat.height = r_h;
        o_beat.maxval = n_mx;
        o_beat.err    = r_err;
        o_beat.hdr_ok = (n_ph == PH_AFTER_CR || n_ph == PH_RASTER) && n_err == ST_OK;
        // size check runs at the back; an overflow turns the rest into don't-care
        if (i_end_of_file) begin
            n_ph = PH_P; n_cmt = 1'b0; n_acc = '0; n_dig = 1'b0;
            n_w = '0; n_h = '0; n_mx = '0; n_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_P; r_cmt <= 1'b0; r_acc <= '0; r_dig <= 1'b0;
            r_w <= '0; r_h <= '0; r_mx <= '0; r_err <= ST_OK;
        end else if (i_valid && i_take) begin
            r_ph <= n_ph; r_cmt <= n_cmt; r_acc <= n_acc; r_dig <= n_dig;
            r_w <= n_w; r_h <= n_h; r_mx <= n_mx; r_err <= n_err;
        end
    end

endmodule

// ----- rtl/core/pgmc_queue.sv -----
module pgmc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pgmc_pkg::t_beat   i_beat,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_avail,
    output pgmc_pkg::t_beat   o_beat
);
    import pgmc_pkg::*;

    t_beat        r_mem [QDEPTH];
    logic [QAW:0] r_wp, r_rp;

    assign o_full  = (r_wp[QAW] != r_rp[QAW]) && (r_wp[QAW-1:0] == r_rp[QAW-1:0]);
    assign o_avail = r_wp != r_rp;
    assign o_beat  = r_mem[r_rp[QAW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp[QAW-1:0]] <= i_beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("queue overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_pop && !o_avail))
        else $error("queue underrun");

endmodule

// ----- rtl/core/pgmc_back.sv -----
module pgmc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  pgmc_pkg::t_beat   i_beat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_kind,
    output logic [15:0]       o_sample_value,
    output logic [31:0]       o_image_width,
    output logic [31:0]       o_image_height,
    output logic [15:0]       o_max_value,
    output logic [1:0]        o_bytes_per_sample,
    output logic [2:0]        o_status,
    output logic              o_last_of_item
);
    import pgmc_pkg::*;

    // setup stage: separator beat waits at the head while width*height is formed
    logic [63:0] r_exp, r_cnt;
    logic [63:0] r_prod;
    logic        r_two;
    logic        r_ovf;
    logic [1:0]  r_setup_cnt;
    logic        r_setup_arm;
    logic [7:0]  r_hi;
    logic        r_above;
    logic        r_pend;          // report of a two-result beat waits; beat stays queued
    logic        r_ov;
    logic        r_kind;

    logic        busy, out_free, need2, fire, emit;
    logic        smp, done_smp;
    logic [15:0] v;
    logic [2:0]  st;
    logic        above_n;
    logic [63:0] cnt_n;

    assign out_free = !r_ov || !i_stall;
    assign busy     = r_setup_cnt != 2'd0;
    assign smp      = i_beat.raster && !r_ovf && i_beat.err == ST_OK && r_cnt < r_exp;
    assign done_smp = smp && (!r_two || r_cnt[0]);
    assign v        = r_two ? {r_hi, i_beat.data} : {8'b0, i_beat.data};
    assign need2    = done_smp && i_beat.eof;
    assign fire     = i_avail && !busy && out_free && !r_pend && !(i_beat.setup && r_setup_cnt == 2'd0 && !r_setup_arm);
    assign emit     = (r_pend && out_free) || (fire && (i_beat.eof || done_smp));
    assign o_pop    = (fire && !need2) || (r_pend && out_free);

    assign above_n = r_above || (done_smp && v > i_beat.maxval);
    assign cnt_n   = (i_beat.raster && r_cnt != '1) ? r_cnt + 64'd1 : r_cnt;

    always_comb begin
        if (i_beat.err != ST_OK)      st = i_beat.err;
        else if (r_ovf)               st = ST_OVERFLOW;
        else if (!i_beat.hdr_ok)      st = ST_HEADER;
        else if (cnt_n != r_exp)      st = ST_LENGTH;
        else if (above_n)             st = ST_ABOVE;
        else                          st = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_cnt <= 2'd0; r_setup_arm <= 1'b0; r_ov <= 1'b0; r_pend <= 1'b0;
            r_cnt <= '0; r_exp <= '0; r_above <= 1'b0; r_ovf <= 1'b0; r_two <= 1'b0;
        end else begin
            r_ov <= emit || (r_ov && i_stall);
            // load expected size before the separator beat is used
            if (i_avail && i_beat.setup && !r_setup_arm && r_setup_cnt == 2'd0) begin
                r_setup_cnt <= 2'd2;
                r_two  <= i_beat.maxval > 16'd255;
            end else if (r_setup_cnt == 2'd2) begin
                r_setup_cnt <= 2'd1;
                r_prod <= 64'(i_beat.width) * 64'(i_beat.height);
            end else if (r_setup_cnt == 2'd1) begin
                r_setup_cnt <= 2'd0;
                r_setup_arm <= 1'b1;
                r_ovf <= r_two ? (r_prod[63:62] != 2'b0) : r_prod[63];
                r_exp <= r_two ? {r_prod[62:0], 1'b0} : r_prod;
            end
            if (r_pend && out_free) begin
                r_pend <= 1'b0;
                r_kind <= 1'b1; o_sample_value <= '0; o_last_of_item <= 1'b1;
                o_status <= st; r_cnt <= '0; r_exp <= '0; r_above <= 1'b0;
                r_ovf <= 1'b0; r_two <= 1'b0; r_setup_arm <= 1'b0;
                o_image_width  <= st == ST_HEADER ? '0 : i_beat.width;
                o_image_height <= st == ST_HEADER ? '0 : i_beat.height;
                o_max_value    <= st == ST_HEADER ? '0 : i_beat.maxval;
                o_bytes_per_sample <= st == ST_HEADER ? 2'd0 :
                                      (i_beat.maxval > 16'd255 ? 2'd2 : 2'd1);
            end else if (fire) begin
                if (smp && !done_smp) r_hi <= i_beat.data;
                if (need2) begin
                    r_pend <= 1'b1;
                    r_kind <= 1'b0; o_sample_value <= v;
                    o_image_width <= '0; o_image_height <= '0; o_max_value <= '0;
                    o_bytes_per_sample <= '0; o_status <= ST_OK; o_last_of_item <= 1'b0;
                end else if (i_beat.eof) begin
                    r_kind <= 1'b1; o_sample_value <= '0;
                    o_last_of_item <= 1'b1; o_status <= st;
                    o_image_width  <= st == ST_HEADER ? '0 : i_beat.width;
                    o_image_height <= st == ST_HEADER ? '0 : i_beat.height;
                    o_max_value    <= st == ST_HEADER ? '0 : i_beat.maxval;
                    o_bytes_per_sample <= st == ST_HEADER ? 2'd0 :
                                          (i_beat.maxval > 16'd255 ? 2'd2 : 2'd1);
                    r_cnt <= '0; r_exp <= '0; r_above <= 1'b0; r_ovf <= 1'b0;
                    r_two <= 1'b0; r_setup_arm <= 1'b0;
                end else begin
                    r_cnt <= cnt_n; r_above <= above_n;
                    if (done_smp) begin
                        r_kind <= 1'b0; o_sample_value <= v;
                        o_image_width <= '0; o_image_height <= '0; o_max_value <= '0;
                        o_bytes_per_sample <= '0; o_status <= ST_OK;
                        o_last_of_item <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_kind  = r_kind;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_pend |-> r_ov)
        else $error("pending report without sample");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) fire |-> !busy)
        else $error("beat taken during size setup");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind) |-> o_last_of_item)
        else $error("report not last of beat");

endmodule

// ----- rtl/core/pgm_p5_stream_checker_core.sv -----
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | i_data_byte, i_end_of_file
// result  | out       | o_valid / i_stall  | o_kind .. o_last_of_item
// One byte a cycle is accepted while the four-entry queue has room; the back
// drains one beat a cycle unless output stall, size setup or a pending report
// holds it. Maxval's separator beat waits at the queue head while width*height
// is multiplied. A byte that ends a sample and the file gives two results.
// Reset clears all parse state; output stalls fill the queue, then o_stall rises.
module pgm_p5_stream_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [15:0] o_sample_value,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic [15:0] o_max_value,
    output logic [1:0]  o_bytes_per_sample,
    output logic [2:0]  o_status,
    output logic        o_last_of_item
);
    import pgmc_pkg::*;

    t_beat f_beat, q_beat;
    logic  full, avail, pop;

    assign o_stall = full;

    pgmc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_data_byte, .i_end_of_file,
        .i_take(!full), .o_beat(f_beat)
    );

    pgmc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(i_valid && !full), .i_beat(f_beat), .o_full(full),
        .i_pop(pop), .o_avail(avail), .o_beat(q_beat)
    );

    pgmc_back u_back (
        .i_clk, .i_rst_n, .i_avail(avail), .i_beat(q_beat), .o_pop(pop),
        .o_valid, .i_stall, .o_kind, .o_sample_value, .o_image_width,
        .o_image_height, .o_max_value, .o_bytes_per_sample, .o_status,
        .o_last_of_item
    );

endmodule

// ----- bench/tb_pgm_p5_stream_checker_core.sv -----
`timescale 1ns / 1ps

module tb_pgm_p5_stream_checker_core;
    import pgmc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_file;
    logic        o_valid;
    logic        i_stall;
    logic        o_kind;
    logic [15:0] o_sample_value;
    logic [31:0] o_image_width;
    logic [31:0] o_image_height;
    logic [15:0] o_max_value;
    logic [1:0]  o_bytes_per_sample;
    logic [2:0]  o_status;
    logic        o_last_of_item;

    pgm_p5_stream_checker_core i_dut (.*);

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_byte_in;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] maxval;
        logic [1:0]  bps;
        logic [2:0]  status;
        logic        last;
    } t_result;

    t_byte_in file_q[$];
    t_result  result_q[$];

    // predictor state
    t_phase      ph;
    logic        cmt;
    logic [31:0] acc;
    logic        dig;
    logic [31:0] hw, hh;
    logic [15:0] hm;
    logic [63:0] exp_bytes, rcount;
    logic [7:0]  hi_hold;
    logic [2:0]  ferr;
    logic        above;

    int  errors = 0;
    int  send_idle = 8;
    int  recv_idle = 51;
    int  hold_recv = 0;
    int  quiet = 0;

    function automatic bit sp(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D ||
               b == 8'h0B || b == 8'h0C;
    endfunction

    task automatic pred_reset();
        ph = PH_P; cmt = 0; acc = 0; dig = 0; hw = 0; hh = 0; hm = 0;
        exp_bytes = 0; rcount = 0; hi_hold = 0; ferr = ST_OK; above = 0;
    endtask

    task automatic fault();
        ferr = ST_HEADER;
        ph = PH_SINK;
    endtask

    task automatic push_sample(input logic [7:0] b, inout int n);
        t_result r;
        logic [15:0] v;
        bit done;
        done = 0;
        v = 0;
        if (rcount < exp_bytes) begin
            if (hm <= 255) begin
                v = {8'b0, b}; done = 1;
            end else if (!rcount[0]) begin
                hi_hold = b;
            end else begin
                v = {hi_hold, b}; done = 1;
            end
            if (done) begin
                r = '0;
                r.sample = v;
                if (v > hm) above = 1;
                result_q.insert(result_q.size(), r);
                n++;
            end
        end
        if (rcount != 64'hFFFF_FFFF_FFFF_FFFF) rcount++;
    endtask

    task automatic end_maxval(input logic [7:0] sep);
        logic [63:0] samples, lim;
        if (acc > 65535) begin
            fault();
            return;
        end
        hm = acc[15:0];
        samples = 64'(hw) * 64'(hh);
        lim = (hm <= 255) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h3FFF_FFFF_FFFF_FFFF;
        if (samples > lim) begin
            ferr = ST_OVERFLOW;
            ph = PH_SINK;
            return;
        end
        exp_bytes = (hm <= 255) ? samples : {samples[62:0], 1'b0};
        ph = (sep == 8'h0D) ? PH_AFTER_CR : PH_RASTER;
    endtask

    task automatic header_number(input logic [7:0] b);
        bit d;
        logic [35:0] nxt;
        d = b >= "0" && b <= "9";
        if (cmt) begin
            if (b == 8'h0D || b == 8'h0A) cmt = 0;
            return;
        end
        if (!dig) begin
            if (sp(b)) return;
            if (b == "#") begin
                cmt = 1;
                return;
            end
            if (!d) begin
                fault();
                return;
            end
            acc = {28'b0, b[3:0]};
            dig = 1;
            return;
        end
        if (d) begin
            nxt = 36'(acc) * 36'd10 + {32'b0, b[3:0]};
            if (nxt > 36'hFFFF_FFFF) begin
                fault();
                return;
            end
            acc = nxt[31:0];
            return;
        end
        if ((!sp(b) && b != "#") || acc == 0) begin
            fault();
            return;
        end
        if (ph == PH_MAXVAL) begin
            if (!sp(b)) begin
                fault();
                return;
            end
            dig = 0;
            end_maxval(b);
            acc = 0;
            return;
        end
        if (ph == PH_WIDTH) hw = acc; else hh = acc;
        acc = 0;
        dig = 0;
        cmt = (b == "#");
        ph = (ph == PH_WIDTH) ? PH_HEIGHT : PH_MAXVAL;
    endtask

    task automatic predict_byte(input t_byte_in it);
        int n;
        t_result r;
        logic [2:0] st;
        n = 0;
        case (ph)
            PH_P:    if (it.data == "P") ph = PH_FIVE; else fault();
            PH_FIVE: if (it.data == "5") ph = PH_SEP; else fault();
            PH_SEP:  if (sp(it.data)) ph = PH_WIDTH; else fault();
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL: header_number(it.data);
            PH_AFTER_CR: begin
                ph = PH_RASTER;
                if (it.data != 8'h0A) push_sample(it.data, n);
            end
            PH_RASTER: push_sample(it.data, n);
            default: ph = PH_SINK;
        endcase
        if (it.eof) begin
            if (ferr != ST_OK) st = ferr;
            else if (ph == PH_AFTER_CR || ph == PH_RASTER)
                st = (rcount != exp_bytes) ? ST_LENGTH : (above ? ST_ABOVE : ST_OK);
            else st = ST_HEADER;
            r = '0;
            r.kind = 1;
            if (st != ST_HEADER) begin
                r.width = hw; r.height = hh; r.maxval = hm;
                r.bps = (hm <= 255) ? 2'd1 : 2'd2;
            end
            r.status = st;
            result_q.insert(result_q.size(), r);
            n++;
            pred_reset();
        end
        if (n > 0) result_q[$].last = 1;
    endtask

    // ---------------- stimulus builders
    task automatic put(input logic [7:0] b, input bit e = 0);
        t_byte_in x;
        x.data = b;
        x.eof = e;
        file_q.insert(file_q.size(), x);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0D;
            4: return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_sep();
        if ($urandom_range(0, 5) == 0) begin
            put(rand_space());
            put("#");
            put($urandom_range(0, 1) ? "x" : 8'hFF);
            put($urandom_range(0, 1) ? 8'h0A : 8'h0D);
        end else begin
            put(rand_space());
        end
    endtask

    // random well-formed file, with the odd fault
    task automatic put_file();
        int w, h, mv, bps, nb, mode;
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 3);
        mv = $urandom_range(0, 1) ? $urandom_range(1, 255) : $urandom_range(256, 65535);
        bps = mv > 255 ? 2 : 1;
        mode = $urandom_range(0, 9);
        put_str("P5");
        put(rand_space());
        put_str($sformatf("%0d", w)); put_sep();
        put_str($sformatf("%0d", h)); put_sep();
        put_str($sformatf("%0d", mv));
        put(mode == 0 ? 8'h0D : rand_space());
        if (mode == 0 && $urandom_range(0, 1)) put(8'h0A);
        nb = w * h * bps;
        if (mode == 1) nb += $urandom_range(1, 3);
        if (mode == 2) nb -= 1;
        if (mode == 3) begin
            put(rand_byte(), 1);
            return;
        end
        if (nb <= 0) begin
            file_q[$].eof = 1;
            return;
        end
        for (int i = 0; i < nb; i++) put(rand_byte(), i == nb - 1);
    endtask

    task automatic put_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) put(rand_byte(), i == n - 1);
    endtask

    // ---------------- clock, reset
    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // ---------------- driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_byte('{data: i_data_byte, eof: i_end_of_file});
            end
            if (!i_valid || !o_stall) begin
                if (file_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_valid       <= 1;
                    i_data_byte   <= file_q[0].data;
                    i_end_of_file <= file_q[0].eof;
                    void'(file_q.pop_front());
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // ---------------- monitor
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_kind, o_sample_value, o_image_width, o_image_height,
                        o_max_value, o_bytes_per_sample, o_status, o_last_of_item};
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
            if (hold_recv > 0) begin
                hold_recv <= hold_recv - 1;
                i_stall <= 1;
            end else begin
                i_stall <= $urandom_range(0, 99) < recv_idle;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet > 2000) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (file_q.size() > 0 || i_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_data_byte = 0;
        i_end_of_file = 0;
        pred_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes of the header fields, CR LF, comments, faults
        put_str("P5 1 1 255\n"); put(8'hFF, 1);
        put_str("P5\t1#c\r1 65535\r\n"); put(8'hFF); put(8'hFF, 1);
        put_str("P5 4294967295 4294967295 65535 "); put(8'h00, 1);
        put_str("P5 1 1 1\r"); put(8'h02, 1);
        put_str("P5 1 1 65536 "); put(8'h00, 1);
        put_str("P5 4294967296 "); put(8'h00, 1);
        put_str("P5 0 1 1 "); put(8'h00, 1);
        put_str("P5 1 1 9#"); put(8'h00, 1);
        put_str("P6"); put(8'h00, 1);
        put_str("P5x"); put(8'h00, 1);
        put_str("P5 1 #abc"); put("d", 1);
        put_str("P5 2 1 1a"); put(8'h00, 1);
        put_str("P5 1 1 1 "); put(8'h00); put(8'h00, 1);
        put_str("P5 3 2 255"); put(8'h20, 1);
        put(8'h00, 1);
        wait_drained();

        // sender pauses until empty, then receiver holds off long
        for (int i = 0; i < 3; i++) put_file();
        wait_drained();
        hold_recv = 200;
        for (int i = 0; i < 4; i++) put_file();
        wait_drained();

        for (int ph_i = 0; ph_i < 3; ph_i++) begin
            if (ph_i == 1) begin send_idle = 51; recv_idle = 8; end
            if (ph_i == 2) begin send_idle = 0; recv_idle = 0; end
            for (int i = 0; i < 4; i++) begin
                if ($urandom_range(0, 7) == 0) put_noise(); else put_file();
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
